// ----- hdl/cdsc_pkg.sv -----
// Package for the calendar date step counter: field widths, operation and
// state codes, the held-date record and the month-length helpers.
// Depends on nothing; every other file imports it.
`default_nettype none

package cdsc_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int STEP_W  = 16;
    localparam int CENT_W  = 7;

    localparam int unsigned MAX_STEP_DEF = 65535;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_MAX   = 5'd31;
    localparam logic [CENT_W-1:0]  CENT_LAST = 7'd99;

    // Reset date 2000-01-01.
    localparam logic [YEAR_W-1:0]  YEAR_RST = 14'd2000;
    localparam logic [CENT_W-1:0]  YHI_RST  = 7'd20;

    // Division of a year by 100 as (year * 5243) >> 19, exact below 43699.
    localparam int RECIP_W     = 27;
    localparam logic [RECIP_W-1:0] RECIP_100 = 27'd5243;
    localparam int RECIP_SHIFT = 19;
    localparam logic [YEAR_W-1:0]  CENTURY = 14'd100;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_CMP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REL_EQUAL   = 2'd0,
        REL_LATER   = 2'd1,
        REL_EARLIER = 2'd2
    } rel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SPLIT,
        ST_CLAMP,
        ST_STEP,
        ST_FINISH
    } state_t;

    // The year is kept both whole and split into century and year of century,
    // so that the leap rule needs no division.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [CENT_W-1:0]  yhi;
        logic [CENT_W-1:0]  ylo;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    function automatic logic is_leap(input logic [CENT_W-1:0] yhi,
                                     input logic [CENT_W-1:0] ylo);
        logic leap;
        if (ylo == '0) begin
            leap = (yhi[1:0] == 2'b00);
        end else begin
            leap = (ylo[1:0] == 2'b00);
        end
        return leap;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = DAY_MAX;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cdsc_if.sv -----
// Handshake channels of the calendar date step counter: request and response.
// Depends on cdsc_pkg for the field widths.
`default_nettype none

interface cdsc_req_if
    import cdsc_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [DAY_W-1:0]     day_in;
    logic [MONTH_W-1:0]   month_in;
    logic [YEAR_W-1:0]    year_in;
    logic [STEP_W-1:0]    step_count;

    modport source (output valid, opcode, day_in, month_in, year_in, step_count,
                    input ready);
    modport sink   (input valid, opcode, day_in, month_in, year_in, step_count,
                    output ready);
endinterface

interface cdsc_rsp_if
    import cdsc_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [DAY_W-1:0]     day_out;
    logic [MONTH_W-1:0]   month_out;
    logic [YEAR_W-1:0]    year_out;
    logic [1:0]           relation;
    logic                 saturated;

    modport source (output valid, day_out, month_out, year_out, relation, saturated,
                    input ready);
    modport sink   (input valid, day_out, month_out, year_out, relation, saturated,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/cdsc_day_step.sv -----
// One-day step of a held date, forwards or backwards, with month lengths
// and the leap rule. Depends on cdsc_pkg; range limits are checked by the caller.
`default_nettype none

module cdsc_day_step
    import cdsc_pkg::*;
(
    input  date_t cur,
    input  logic  back,
    output date_t nxt
);

    logic             leap;
    logic [DAY_W-1:0] cur_len;
    logic [DAY_W-1:0] prev_len;
    logic [MONTH_W-1:0] prev_month;

    assign leap       = is_leap(cur.yhi, cur.ylo);
    assign cur_len    = month_len(cur.month, leap);
    assign prev_month = cur.month - MONTH_MIN;
    assign prev_len   = month_len(prev_month, leap);

    always_comb
    begin
        nxt = cur;
        if (!back) begin
            if (cur.day < cur_len) begin
                nxt.day = cur.day + DAY_MIN;
            end else begin
                nxt.day = DAY_MIN;
                if (cur.month < MONTH_MAX) begin
                    nxt.month = cur.month + MONTH_MIN;
                end else begin
                    nxt.month = MONTH_MIN;
                    nxt.year  = cur.year + 14'd1;
                    if (cur.ylo == CENT_LAST) begin
                        nxt.ylo = '0;
                        nxt.yhi = cur.yhi + 7'd1;
                    end else begin
                        nxt.ylo = cur.ylo + 7'd1;
                    end
                end
            end
        end else begin
            if (cur.day > DAY_MIN) begin
                nxt.day = cur.day - DAY_MIN;
            end else if (cur.month > MONTH_MIN) begin
                nxt.month = prev_month;
                nxt.day   = prev_len;
            end else begin
                nxt.month = MONTH_MAX;
                nxt.day   = DAY_MAX;
                nxt.year  = cur.year - 14'd1;
                if (cur.ylo == '0) begin
                    nxt.ylo = CENT_LAST;
                    nxt.yhi = cur.yhi - 7'd1;
                end else begin
                    nxt.ylo = cur.ylo - 7'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/calendar_date_step_counter_top.sv -----
// Top level of the calendar date step counter: sequencer, held date and
// response register. Depends on cdsc_pkg, cdsc_if and cdsc_day_step.
`default_nettype none

// Channel  Role   Fields                                              Meaning
// req      sink   opcode, day_in, month_in, year_in, step_count      one operation per beat
// rsp      source day_out, month_out, year_out, relation, saturated  held date after it
//
// A beat moves on a rising clock edge with valid and ready both high. The block
// works on one request at a time; ready is high only while the sequencer is idle.
// Compare goes from idle straight to the finishing state, load passes through the
// divide, split and clamp states, and add or subtract stays in the step state for
// the clamped step count or until a range limit stops the walk: the shared day-step
// unit moves the date by one day per cycle. The response sits in its own register,
// so a new request is taken while the previous response waits; only the finishing
// cycle stalls on rsp.ready. Reset (rst_n low, asynchronous) sets the date to
// 2000-01-01 and empties the response register.

module calendar_date_step_counter_top
    import cdsc_pkg::*;
#(
    parameter int unsigned MAX_STEP = MAX_STEP_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    cdsc_req_if.sink   req,
    cdsc_rsp_if.source rsp
);

    // The request count is 16 bits wide, so the cap never exceeds 65535.
    localparam int unsigned STEP_CAP = (MAX_STEP < MAX_STEP_DEF) ? MAX_STEP : MAX_STEP_DEF;
    localparam logic [STEP_W-1:0] STEP_CAP_V = STEP_W'(STEP_CAP);

    state_t state_reg, state_next;

    op_t                op_reg, op_next;
    logic [DAY_W-1:0]   d_reg, d_next;
    logic [MONTH_W-1:0] m_reg, m_next;
    logic [YEAR_W-1:0]  y_reg, y_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [CENT_W-1:0]  q_reg, q_next;
    date_t              date_reg, date_next;
    rel_t               rel_reg, rel_next;
    logic               sat_reg, sat_next;

    logic               rsp_valid_reg, rsp_valid_next;
    date_t              rsp_date_reg, rsp_date_next;
    rel_t               rsp_rel_reg, rsp_rel_next;
    logic               rsp_sat_reg, rsp_sat_next;

    date_t              step_date;
    logic               at_limit;
    logic               accept;
    logic               rsp_free;
    logic [RECIP_W-1:0] recip_prod;
    logic [YEAR_W-1:0]  cent_prod;
    logic [YEAR_W-1:0]  rem_year;
    logic [DAY_W-1:0]   load_len;

    cdsc_day_step u_day_step (
        .cur  (date_reg),
        .back (op_reg == OP_SUB),
        .nxt  (step_date)
    );

    assign accept   = req.valid && req.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    // Forward stepping stops at the last day of year 9999, backward at the first of year 1.
    assign at_limit = (op_reg == OP_SUB) ?
        (date_reg.year == YEAR_MIN && date_reg.month == MONTH_MIN && date_reg.day == DAY_MIN) :
        (date_reg.year == YEAR_MAX && date_reg.month == MONTH_MAX && date_reg.day == DAY_MAX);

    // Load splits the clamped year into century and year of century in the divide and split states.
    assign recip_prod = RECIP_W'(y_reg) * RECIP_100;
    assign cent_prod  = YEAR_W'(q_reg) * CENTURY;
    assign rem_year   = y_reg - cent_prod;
    assign load_len   = month_len(date_reg.month, is_leap(date_reg.yhi, date_reg.ylo));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    case (op_t'(req.opcode))
                        OP_LOAD: state_next = ST_DIV;
                        OP_ADD,
                        OP_SUB:  state_next = ST_STEP;
                        default: state_next = ST_FINISH;
                    endcase
                end
            end
            ST_DIV:    state_next = ST_SPLIT;
            ST_SPLIT:  state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_FINISH;
            ST_STEP:
            begin
                if (cnt_reg == '0 || at_limit) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (rsp_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        d_next         = d_reg;
        m_next         = m_reg;
        y_next         = y_reg;
        cnt_next       = cnt_reg;
        q_next         = q_reg;
        date_next      = date_reg;
        rel_next       = rel_reg;
        sat_next       = sat_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_date_next  = rsp_date_reg;
        rsp_rel_next   = rsp_rel_reg;
        rsp_sat_next   = rsp_sat_reg;

        if (rsp_valid_reg && rsp.ready) begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    op_next  = op_t'(req.opcode);
                    d_next   = req.day_in;
                    sat_next = 1'b0;
                    cnt_next = (req.step_count > STEP_CAP_V) ? STEP_CAP_V : req.step_count;

                    // A load clamps month and year into range before the day is fitted.
                    if (req.month_in < MONTH_MIN) begin
                        m_next = MONTH_MIN;
                    end else if (req.month_in > MONTH_MAX) begin
                        m_next = MONTH_MAX;
                    end else begin
                        m_next = req.month_in;
                    end
                    if (req.year_in < YEAR_MIN) begin
                        y_next = YEAR_MIN;
                    end else if (req.year_in > YEAR_MAX) begin
                        y_next = YEAR_MAX;
                    end else begin
                        y_next = req.year_in;
                    end

                    // Compare uses the raw fields: year first, then month, then day.
                    if (op_t'(req.opcode) != OP_CMP) begin
                        rel_next = REL_EQUAL;
                    end else if (date_reg.year != req.year_in) begin
                        rel_next = (date_reg.year > req.year_in) ? REL_LATER : REL_EARLIER;
                    end else if (date_reg.month != req.month_in) begin
                        rel_next = (date_reg.month > req.month_in) ? REL_LATER : REL_EARLIER;
                    end else if (date_reg.day != req.day_in) begin
                        rel_next = (date_reg.day > req.day_in) ? REL_LATER : REL_EARLIER;
                    end else begin
                        rel_next = REL_EQUAL;
                    end
                end
            end
            ST_DIV:
            begin
                q_next = recip_prod[RECIP_SHIFT +: CENT_W];
            end
            ST_SPLIT:
            begin
                date_next.year  = y_reg;
                date_next.yhi   = q_reg;
                date_next.ylo   = rem_year[CENT_W-1:0];
                date_next.month = m_reg;
                date_next.day   = DAY_MIN;
            end
            ST_CLAMP:
            begin
                if (d_reg < DAY_MIN) begin
                    date_next.day = DAY_MIN;
                end else if (d_reg > load_len) begin
                    date_next.day = load_len;
                end else begin
                    date_next.day = d_reg;
                end
            end
            ST_STEP:
            begin
                if (cnt_reg != '0) begin
                    if (at_limit) begin
                        sat_next = 1'b1;
                    end else begin
                        date_next = step_date;
                        cnt_next  = cnt_reg - 16'd1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (rsp_free) begin
                    rsp_valid_next = 1'b1;
                    rsp_date_next  = date_reg;
                    rsp_rel_next   = rel_reg;
                    rsp_sat_next   = sat_reg;
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            date_reg.year  <= YEAR_RST;
            date_reg.yhi   <= YHI_RST;
            date_reg.ylo   <= '0;
            date_reg.month <= MONTH_MIN;
            date_reg.day   <= DAY_MIN;
        end else begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            date_reg       <= date_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        d_reg        <= d_next;
        m_reg        <= m_next;
        y_reg        <= y_next;
        cnt_reg      <= cnt_next;
        q_reg        <= q_next;
        rel_reg      <= rel_next;
        sat_reg      <= sat_next;
        rsp_date_reg <= rsp_date_next;
        rsp_rel_reg  <= rsp_rel_next;
        rsp_sat_reg  <= rsp_sat_next;
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.day_out   = rsp_date_reg.day;
    assign rsp.month_out = rsp_date_reg.month;
    assign rsp.year_out  = rsp_date_reg.year;
    assign rsp.relation  = rsp_rel_reg;
    assign rsp.saturated = rsp_sat_reg;

endmodule

`default_nettype wire

// ----- tb/calendar_date_step_counter_top_tb.sv -----
// Self-checking testbench for the calendar date step counter top level.
// Depends on cdsc_pkg, the cdsc_req_if and cdsc_rsp_if channels and the RTL top;
// it predicts every response with its own calendar arithmetic and checks it.
`default_nettype none

module calendar_date_step_counter_top_tb
    import cdsc_pkg::*;
    ();

    // Chance in a hundred that a side idles in any one cycle.
    localparam int unsigned IDLE_PCT      = 12;
    // Random beats sent after the directed part.
    localparam int unsigned RANDOM_ITEMS  = 75;
    // Window of random beats during which neither side idles.
    localparam int unsigned STEADY_FROM   = 30;
    localparam int unsigned STEADY_TO     = 60;
    // Cycles allowed for the block to settle once the last response is in.
    localparam int unsigned SETTLE_CYCLES = 20;
    // Hard limit on the run. The slowest correct run, with every beat stepping
    // the full count and every response stalled, stays well below a tenth of it.
    localparam longint unsigned WATCHDOG_TIME = 1_000_000_000;

    // One request beat as the sender sees it.
    typedef struct {
        op_t                op;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [STEP_W-1:0]  steps;
    } req_beat_t;

    // One response beat: the held date after the operation and its flags.
    typedef struct {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        rel_t               rel;
        logic               sat;
    } date_result_t;

    // The scoreboard keeps its own copy of the held date. Each accepted request
    // moves that copy exactly as the block should, and the resulting date is
    // queued; each accepted response is checked against the oldest entry.
    class date_scoreboard;
        logic [DAY_W-1:0]   held_day;
        logic [MONTH_W-1:0] held_month;
        logic [YEAR_W-1:0]  held_year;
        date_result_t       expected_dates[$];
        int unsigned        mismatches;

        function new();
            held_day   = DAY_MIN;
            held_month = MONTH_MIN;
            held_year  = YEAR_RST;
            mismatches = 0;
        endfunction

        // Gregorian rule: every fourth year, except centuries not divisible by 400.
        static function bit leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int unsigned month_days(int unsigned m, int unsigned y);
            if (m == 4 || m == 6 || m == 9 || m == 11) begin
                return 30;
            end else if (m == 2) begin
                return leap_year(y) ? 29 : 28;
            end
            return 31;
        endfunction

        function int unsigned pending();
            return expected_dates.size();
        endfunction

        function void note_request(req_beat_t b);
            date_result_t       r;
            int unsigned        n;
            int unsigned        i;
            int unsigned        len;
            logic [DAY_W-1:0]   d;
            logic [MONTH_W-1:0] m;
            logic [YEAR_W-1:0]  y;

            r.rel = REL_EQUAL;
            r.sat = 1'b0;
            n = b.steps;
            if (n > MAX_STEP_DEF) begin
                n = MAX_STEP_DEF;
            end

            case (b.op)
                OP_LOAD:
                begin
                    // Month and year are clamped first; the day then follows the
                    // length of that month, so the held date is always valid.
                    m = b.month;
                    y = b.year;
                    d = b.day;
                    if (m < MONTH_MIN) m = MONTH_MIN;
                    if (m > MONTH_MAX) m = MONTH_MAX;
                    if (y < YEAR_MIN)  y = YEAR_MIN;
                    if (y > YEAR_MAX)  y = YEAR_MAX;
                    len = month_days(m, y);
                    if (d < DAY_MIN) d = DAY_MIN;
                    if (d > len)     d = DAY_W'(len);
                    held_day   = d;
                    held_month = m;
                    held_year  = y;
                end
                OP_ADD:
                begin
                    i = 0;
                    while (i < n && !r.sat) begin
                        if (held_year == YEAR_MAX && held_month == MONTH_MAX &&
                            held_day == DAY_MAX) begin
                            r.sat = 1'b1;
                        end else begin
                            if (held_day < month_days(held_month, held_year)) begin
                                held_day++;
                            end else begin
                                held_day = DAY_MIN;
                                if (held_month < MONTH_MAX) begin
                                    held_month++;
                                end else begin
                                    held_month = MONTH_MIN;
                                    held_year++;
                                end
                            end
                            i++;
                        end
                    end
                end
                OP_SUB:
                begin
                    i = 0;
                    while (i < n && !r.sat) begin
                        if (held_year == YEAR_MIN && held_month == MONTH_MIN &&
                            held_day == DAY_MIN) begin
                            r.sat = 1'b1;
                        end else begin
                            if (held_day > DAY_MIN) begin
                                held_day--;
                            end else if (held_month > MONTH_MIN) begin
                                held_month--;
                                held_day = DAY_W'(month_days(held_month, held_year));
                            end else begin
                                held_month = MONTH_MAX;
                                held_year--;
                                held_day = DAY_MAX;
                            end
                            i++;
                        end
                    end
                end
                default:
                begin
                    // The operand is taken as given: year, then month, then day.
                    if (held_year != b.year) begin
                        r.rel = (held_year > b.year) ? REL_LATER : REL_EARLIER;
                    end else if (held_month != b.month) begin
                        r.rel = (held_month > b.month) ? REL_LATER : REL_EARLIER;
                    end else if (held_day != b.day) begin
                        r.rel = (held_day > b.day) ? REL_LATER : REL_EARLIER;
                    end
                end
            endcase

            r.day   = held_day;
            r.month = held_month;
            r.year  = held_year;
            expected_dates.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_response(date_result_t got);
            date_result_t want;

            if (expected_dates.size() == 0) begin
                report_mismatch($sformatf("response %0d-%0d-%0d with nothing outstanding",
                                          got.year, got.month, got.day));
            end else begin
                want = expected_dates.pop_front();
                if (got.day !== want.day || got.month !== want.month ||
                    got.year !== want.year || got.rel !== want.rel ||
                    got.sat !== want.sat) begin
                    report_mismatch($sformatf(
                        "got %0d-%0d-%0d rel %0d sat %0d, want %0d-%0d-%0d rel %0d sat %0d",
                        got.year, got.month, got.day, got.rel, got.sat,
                        want.year, want.month, want.day, want.rel, want.sat));
                end
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   steady = 1'b0;
    int unsigned sent_count = 0;

    date_scoreboard sb = new;

    cdsc_req_if req_ch ();
    cdsc_rsp_if rsp_ch ();

    calendar_date_step_counter_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Period of 10: five high, five low.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The response side stalls at random, except during the steady window.
    always @(posedge clk)
    begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Both channels are sampled at the clock edge, seeing the values that were
    // present as the edge arrived. Requests are noted before responses are
    // checked, although a response can never belong to a beat of the same edge.
    always @(posedge clk)
    begin
        req_beat_t    seen;
        date_result_t got;

        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                seen.op    = op_t'(req_ch.opcode);
                seen.day   = req_ch.day_in;
                seen.month = req_ch.month_in;
                seen.year  = req_ch.year_in;
                seen.steps = req_ch.step_count;
                sb.note_request(seen);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.day   = rsp_ch.day_out;
                got.month = rsp_ch.month_out;
                got.year  = rsp_ch.year_out;
                got.rel   = rel_t'(rsp_ch.relation);
                got.sat   = rsp_ch.saturated;
                sb.check_response(got);
            end
        end
    end

    function automatic req_beat_t mk(op_t op, int unsigned d, int unsigned m,
                                     int unsigned y, int unsigned n);
        req_beat_t b;

        b.op    = op;
        b.day   = DAY_W'(d);
        b.month = MONTH_W'(m);
        b.year  = YEAR_W'(y);
        b.steps = STEP_W'(n);
        return b;
    endfunction

    // Most counts are short so that the run stays brief; a few span the full range.
    function automatic logic [STEP_W-1:0] pick_steps();
        int unsigned r;

        r = $urandom_range(99);
        if (r < 55) begin
            return STEP_W'($urandom_range(40));
        end else if (r < 85) begin
            return STEP_W'($urandom_range(1200, 41));
        end else if (r < 96) begin
            return STEP_W'($urandom_range(8000, 1201));
        end
        return STEP_W'($urandom_range(65535));
    endfunction

    // Presents one beat and returns at the edge where it is accepted. Valid is
    // left high so that back-to-back beats need no gap.
    task automatic send_beat(input req_beat_t b);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= b.op;
        req_ch.day_in     <= b.day;
        req_ch.month_in   <= b.month;
        req_ch.year_in    <= b.year;
        req_ch.step_count <= b.steps;
        @(posedge clk);
        while (!req_ch.ready) begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    // Holds the request side quiet until every queued response has come back.
    // The first edge lets the monitor note a beat accepted at the previous one.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (sb.pending() != 0);
    endtask

    // One random sequence: a load, then a few steps and compares around it.
    // Most loads are valid dates, some sit at the range limits so that a large
    // count saturates quickly, and the rest carry raw field values.
    task automatic random_group();
        req_beat_t         anchor;
        req_beat_t         b;
        int unsigned       kind;
        int unsigned       ops;
        int unsigned       r;
        int unsigned       i;
        int unsigned       y;
        int unsigned       m;
        logic [STEP_W-1:0] n;

        kind = $urandom_range(99);
        if (kind < 8) begin
            if ($urandom_range(1) == 1) begin
                anchor = mk(OP_LOAD, 31 - $urandom_range(3), 12, 9999, $urandom_range(65535));
            end else begin
                anchor = mk(OP_LOAD, 1 + $urandom_range(3), 1, 1, $urandom_range(65535));
            end
        end else if (kind < 85) begin
            y = ($urandom_range(9) == 0) ? 100 * $urandom_range(99, 1) :
                                            $urandom_range(9999, 1);
            m = $urandom_range(12, 1);
            anchor = mk(OP_LOAD,
                        ($urandom_range(4) == 0) ? date_scoreboard::month_days(m, y) :
                            $urandom_range(date_scoreboard::month_days(m, y), 1),
                        m, y, $urandom_range(65535));
        end else begin
            anchor = mk(OP_LOAD, $urandom_range(31), $urandom_range(15),
                        $urandom_range(16383), $urandom_range(65535));
        end
        send_beat(anchor);

        // From a limit date, head straight into the limit with a large count.
        if (kind < 8) begin
            send_beat(mk((anchor.year == YEAR_MAX) ? OP_ADD : OP_SUB, $urandom_range(31),
                         $urandom_range(15), $urandom_range(16383),
                         $urandom_range(65535, 8)));
        end

        ops = $urandom_range(4, 1);
        for (i = 0; i < ops; i++) begin
            r = $urandom_range(99);
            if (r < 30) begin
                send_beat(mk(OP_ADD, $urandom_range(31), $urandom_range(15),
                             $urandom_range(16383), pick_steps()));
            end else if (r < 60) begin
                send_beat(mk(OP_SUB, $urandom_range(31), $urandom_range(15),
                             $urandom_range(16383), pick_steps()));
            end else if (r < 75) begin
                // Out and back by the same count: away from the limits the date
                // returns to where it was; the compare that follows uses the loaded fields.
                n = pick_steps();
                send_beat(mk(OP_ADD, $urandom_range(31), $urandom_range(15),
                             $urandom_range(16383), n));
                send_beat(mk(OP_SUB, $urandom_range(31), $urandom_range(15),
                             $urandom_range(16383), n));
                send_beat(mk(OP_CMP, anchor.day, anchor.month, anchor.year,
                             $urandom_range(65535)));
            end else begin
                b = anchor;
                b.op = OP_CMP;
                b.steps = STEP_W'($urandom_range(65535));
                r = $urandom_range(99);
                if (r >= 75) begin
                    b.day   = DAY_W'($urandom_range(31));
                    b.month = MONTH_W'($urandom_range(15));
                    b.year  = YEAR_W'($urandom_range(16383));
                end else if (r >= 40) begin
                    // Nudge a single field by one either way, or leave it.
                    case ($urandom_range(2))
                        0:       b.day   = DAY_W'(b.day + $urandom_range(2) - 1);
                        1:       b.month = MONTH_W'(b.month + $urandom_range(2) - 1);
                        default: b.year  = YEAR_W'(b.year + $urandom_range(2) - 1);
                    endcase
                end
                send_beat(b);
            end
        end
    endtask

    initial
    begin
        int unsigned random_base;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_LOAD;
        req_ch.day_in      = '0;
        req_ch.month_in    = '0;
        req_ch.year_in     = '0;
        req_ch.step_count  = '0;
        rsp_ch.ready       = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first compare shows the reset date.
        send_beat(mk(OP_CMP,  1,  1,  2000, 0));
        send_beat(mk(OP_ADD,  0,  0,  0,    0));
        // Leap day in a century divisible by 400, then into March.
        send_beat(mk(OP_LOAD, 28, 2,  2000, 0));
        send_beat(mk(OP_ADD,  0,  0,  0,    1));
        send_beat(mk(OP_ADD,  0,  0,  0,    1));
        // A century not divisible by 400 has no leap day.
        send_beat(mk(OP_LOAD, 28, 2,  1900, 0));
        send_beat(mk(OP_ADD,  0,  0,  0,    1));
        // Loads with a day beyond the month length are pulled back.
        send_beat(mk(OP_LOAD, 31, 4,  2023, 0));
        send_beat(mk(OP_LOAD, 30, 2,  2100, 0));
        // All-zero fields load the first date; stepping back from it saturates.
        send_beat(mk(OP_LOAD, 0,  0,  0,    0));
        send_beat(mk(OP_SUB,  0,  0,  0,    1));
        send_beat(mk(OP_LOAD, 5,  1,  1,    0));
        send_beat(mk(OP_SUB,  0,  0,  0,    65535));
        // All-ones fields load the last date; stepping on from it saturates.
        send_beat(mk(OP_LOAD, 31, 15, 16383, 65535));
        send_beat(mk(OP_ADD,  31, 15, 16383, 5));
        send_beat(mk(OP_CMP,  31, 12, 9999, 0));
        send_beat(mk(OP_CMP,  0,  0,  0,    0));
        send_beat(mk(OP_CMP,  31, 15, 16383, 0));
        send_beat(mk(OP_LOAD, 20, 12, 9999, 0));
        send_beat(mk(OP_ADD,  0,  0,  0,    65535));
        // Year boundary in both directions.
        send_beat(mk(OP_LOAD, 31, 12, 1999, 0));
        send_beat(mk(OP_ADD,  0,  0,  0,    1));
        send_beat(mk(OP_SUB,  0,  0,  0,    1));
        // A full-length walk forward and back again, then compares by the day.
        send_beat(mk(OP_LOAD, 1,  1,  2000, 0));
        send_beat(mk(OP_ADD,  0,  0,  0,    65535));
        send_beat(mk(OP_SUB,  0,  0,  0,    65535));
        send_beat(mk(OP_CMP,  2,  1,  2000, 0));

        // Let the block run completely dry before the random part.
        drain();

        random_base = sent_count;
        while (sent_count - random_base < RANDOM_ITEMS) begin
            steady <= (sent_count - random_base >= STEADY_FROM) &&
                      (sent_count - random_base < STEADY_TO);
            random_group();
        end
        steady <= 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Catches a hang: a beat never accepted or a response never returned.
    initial
    begin
        #(WATCHDOG_TIME);
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ----- calendar_date_step_counter_top.f -----
hdl/cdsc_pkg.sv
hdl/cdsc_if.sv
hdl/cdsc_day_step.sv
hdl/calendar_date_step_counter_top.sv
tb/calendar_date_step_counter_top_tb.sv
